// ----- rtl/tlcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types, command codes and the 5x7 font for the text cell LCD byte
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlcd_pkg;

    // request modes
    localparam logic [1:0] MODE_CELL = 2'd0;  // address then character
    localparam logic [1:0] MODE_ADDR = 2'd1;  // address only
    localparam logic [1:0] MODE_HERE = 2'd2;  // character only

    // controller command bytes
    localparam logic [7:0] CMD_BASIC_SET = 8'h20;
    localparam logic [7:0] CMD_SET_X     = 8'h80;
    localparam logic [7:0] CMD_SET_Y     = 8'h40;
    localparam logic [7:0] BLANK_COL     = 8'h00;

    localparam logic [6:0] FIRST_CODE   = 7'd32;
    localparam logic [6:0] MAX_CHAR_COL = 7'd11;
    localparam int         ROM_GLYPHS   = 95;
    localparam int         ROM_COLS     = 5;
    localparam int         COL_W        = 3;   // glyph column index, up to 8 columns

    typedef logic [0:ROM_COLS-1][7:0] glyph_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] x_pos;
        logic [2:0] bank;
        logic [6:0] character;
    } req_t;

    // decoded byte slot, between decode and render
    typedef struct packed {
        logic             valid;
        logic [7:0]       cmd_byte;
        logic             is_data;
        logic             last;
        logic             glyph_ok;
        logic [6:0]       glyph_idx;
        logic [COL_W-1:0] col;
    } slot_t;

    // one row per glyph, column 0 in the leftmost byte
    localparam glyph_t FONT_ROM [0:ROM_GLYPHS-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0003000300, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0000030000, 40'h1C22410000, 40'h000041221C,
        40'h0A041F040A, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h101814127F, 40'h2745454539, 40'h3E49494930, 40'h0371090503, 40'h3649494936,
        40'h064949493E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0601510906, 40'h324979413E, 40'h7C0A090A7C, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7E0106017E, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h2649494932, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4030403F, 40'h6314081463, 40'h0708780807, 40'h6151494543, 40'h7F41410000,
        40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040, 40'h0102040000,
        40'h2054545478, 40'h7F48484830, 40'h3844444444, 40'h304848487F, 40'h3854545458,
        40'h00087E0902, 40'h485454543C, 40'h7F08080870, 40'h00007A0000, 40'h2040403D00,
        40'h007F102844, 40'h00417F4000, 40'h7C0418047C, 40'h7C08040478, 40'h3844444438,
        40'h007C141408, 40'h081414147C, 40'h7C08040408, 40'h4854545424, 40'h04043F4424,
        40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0448300804,
        40'h4464544C44, 40'h0836414100, 40'h00007F0000, 40'h0041413608, 40'h0201020402
    };

endpackage

`default_nettype wire

// ----- rtl/tlcd_if.sv -----
// ----------------------------------------------------------------------------
// tlcd_if
// Valid/ready channels: request words in, display byte words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] x_pos;
    logic [2:0] bank;
    logic [6:0] character;

    modport source (output valid, mode, x_pos, bank, character, input ready);
    modport sink   (input valid, mode, x_pos, bank, character, output ready);
endinterface

interface tlcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;

    modport source (output valid, out_byte, is_data, last, input ready);
    modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlcd_seq.sv -----
// ----------------------------------------------------------------------------
// tlcd_seq
// Holds one request and steps a slot counter through its byte run, one slot
// per advance of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_seq
    import tlcd_pkg::*;
#(
    parameter int GLYPH_COLUMNS = 5,
    parameter int SLOT_W        = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    tlcd_req_if.sink               req,
    output logic                   slot_valid,
    output logic [SLOT_W-1:0]      slot,
    output logic                   slot_last,
    output req_t                   slot_req
);

    // slots: four address commands, blank, glyph columns, blank
    localparam logic [SLOT_W-1:0] SLOT_FIRST_CMD  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_LAST_CMD   = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_FIRST_DATA = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_LAST_DATA  = SLOT_W'(GLYPH_COLUMNS + 5);

    logic              busy_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] end_reg;
    req_t              req_reg;

    logic              slot_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              slot_last_reg;
    req_t              slot_req_reg;

    logic              at_end;
    logic              accept;
    logic              start_run;
    logic [SLOT_W-1:0] start_idx;
    logic [SLOT_W-1:0] end_idx;

    assign at_end    = (idx_reg == end_reg);
    assign req.ready = !busy_reg || (adv && at_end);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        start_run = 1'b1;
        start_idx = SLOT_FIRST_CMD;
        end_idx   = SLOT_LAST_DATA;
        case (req.mode)
            MODE_CELL:
            begin
                start_idx = SLOT_FIRST_CMD;
                end_idx   = SLOT_LAST_DATA;
            end
            MODE_ADDR:
            begin
                start_idx = SLOT_FIRST_CMD;
                end_idx   = SLOT_LAST_CMD;
            end
            MODE_HERE:
            begin
                start_idx = SLOT_FIRST_DATA;
                end_idx   = SLOT_LAST_DATA;
            end
            default:
            begin
                start_run = 1'b0;   // unused mode: swallowed, nothing emitted
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                slot_valid_reg <= busy_reg;
            end
            if (accept)
            begin
                busy_reg <= start_run;
            end
            else if (adv && busy_reg && at_end)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot_reg      <= idx_reg;
            slot_last_reg <= at_end;
            slot_req_reg  <= req_reg;
            if (busy_reg && !at_end)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
        if (accept)
        begin
            idx_reg           <= start_idx;
            end_reg           <= end_idx;
            req_reg.mode      <= req.mode;
            req_reg.x_pos     <= req.x_pos;
            req_reg.bank      <= req.bank;
            req_reg.character <= req.character;
        end
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;
    assign slot_last  = slot_last_reg;
    assign slot_req   = slot_req_reg;

endmodule

`default_nettype wire

// ----- rtl/tlcd_decode.sv -----
// ----------------------------------------------------------------------------
// tlcd_decode
// Turns a slot into a command byte or a glyph column reference.
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_decode
    import tlcd_pkg::*;
#(
    parameter int GLYPH_COUNT   = 95,
    parameter int GLYPH_COLUMNS = 5,
    parameter int SLOT_W        = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              slot_valid,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic              slot_last,
    input  wire req_t              slot_req,
    output slot_t                  dec
);

    localparam logic [SLOT_W-1:0] SLOT_BASIC_A  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_SET_X    = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_BASIC_B  = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_SET_Y    = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_BLANK_HD = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_GLYPH0   = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] SLOT_BLANK_TL = SLOT_W'(GLYPH_COLUMNS + 5);
    localparam logic [7:0]        GLYPH_LIMIT   = 8'(GLYPH_COUNT);

    slot_t      dec_reg;
    logic       dec_valid_reg;
    slot_t      dec_next;
    logic [6:0] col_sat;
    logic [6:0] px;
    logic [6:0] gidx;
    logic [SLOT_W-1:0] col_full;

    always_comb
    begin
        // cell column times seven: x*8 - x
        col_sat  = (slot_req.x_pos > MAX_CHAR_COL) ? MAX_CHAR_COL : slot_req.x_pos;
        px       = (slot_req.mode == MODE_CELL) ? 7'((col_sat << 3) - col_sat)
                                                : slot_req.x_pos;
        gidx     = slot_req.character - FIRST_CODE;
        col_full = slot - SLOT_GLYPH0;

        dec_next           = '0;
        dec_next.valid     = slot_valid;
        dec_next.last      = slot_last;
        dec_next.glyph_idx = gidx;
        dec_next.col       = COL_W'(col_full);
        case (slot)
            SLOT_BASIC_A:  dec_next.cmd_byte = CMD_BASIC_SET;
            SLOT_SET_X:    dec_next.cmd_byte = CMD_SET_X | {1'b0, px};
            SLOT_BASIC_B:  dec_next.cmd_byte = CMD_BASIC_SET;
            SLOT_SET_Y:    dec_next.cmd_byte = CMD_SET_Y | {5'd0, slot_req.bank};
            SLOT_BLANK_HD: dec_next.is_data  = 1'b1;
            default:
            begin
                dec_next.is_data  = 1'b1;
                dec_next.glyph_ok = (slot != SLOT_BLANK_TL)
                                 && (slot_req.character >= FIRST_CODE)
                                 && ({1'b0, gidx} < GLYPH_LIMIT)
                                 && (gidx < 7'(ROM_GLYPHS))
                                 && (col_full < SLOT_W'(ROM_COLS));
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dec_valid_reg <= dec_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg <= dec_next;
        end
    end

    always_comb
    begin
        dec       = dec_reg;
        dec.valid = dec_valid_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/tlcd_render.sv -----
// ----------------------------------------------------------------------------
// tlcd_render
// Font row lookup, then column select into the output register. Drives the
// pipeline advance from the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_render
    import tlcd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire slot_t  dec,
    output logic        adv,
    tlcd_byte_if.source rsp
);

    localparam int ROW_W = $clog2(ROM_GLYPHS);
    localparam int CSEL_W = $clog2(ROM_COLS);

    slot_t  fetch_reg;
    logic   fetch_valid_reg;
    glyph_t row_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_is_data_reg;
    logic       out_last_reg;

    logic [7:0] byte_next;

    assign adv = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (!fetch_reg.is_data)
        begin
            byte_next = fetch_reg.cmd_byte;
        end
        else if (fetch_reg.glyph_ok)
        begin
            byte_next = row_reg[CSEL_W'(fetch_reg.col)];
        end
        else
        begin
            byte_next = BLANK_COL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            fetch_valid_reg <= dec.valid;
            out_valid_reg   <= fetch_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fetch_reg       <= dec;
            row_reg         <= dec.glyph_ok ? FONT_ROM[ROW_W'(dec.glyph_idx)] : '0;
            out_byte_reg    <= byte_next;
            out_is_data_reg <= fetch_reg.is_data;
            out_last_reg    <= fetch_reg.last;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;
    assign rsp.is_data  = out_is_data_reg;
    assign rsp.last     = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/text_cell_lcd_byte_generator_core.sv -----
// ----------------------------------------------------------------------------
// text_cell_lcd_byte_generator_core
// Expands a request into tagged command and pixel bytes for a bank-addressed
// monochrome LCD, drawing characters from a 5x7 font.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                               | handshake
//  --------+-----+------------------------------------+-------------
//  req     | in  | mode, x_pos, bank, character       | valid/ready
//  rsp     | out | out_byte, is_data, last            | valid/ready
//
//  One byte leaves per cycle while rsp.ready is high; a request gives 4
//  (address only), GLYPH_COLUMNS+2 (character only) or GLYPH_COLUMNS+6 bytes,
//  set by the slot counter in the sequencer. From accept, the first byte
//  passes the sequencer, decode, font row and output registers. The next request
//  is taken in the cycle the current one issues its last slot. rsp.ready low
//  while a word waits freezes every stage; reset clears only valid and busy
//  flags.
`default_nettype none

module text_cell_lcd_byte_generator_core
    import tlcd_pkg::*;
#(
    parameter int GLYPH_COUNT   = 95,
    parameter int GLYPH_COLUMNS = 5
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlcd_req_if.sink    req,
    tlcd_byte_if.source rsp
);

    localparam int SLOT_W = $clog2(GLYPH_COLUMNS + 6);

    logic              adv;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot;
    logic              slot_last;
    req_t              slot_req;
    slot_t             dec;

    tlcd_seq #(
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .SLOT_W        (SLOT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .req        (req),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_last  (slot_last),
        .slot_req   (slot_req)
    );

    tlcd_decode #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .SLOT_W        (SLOT_W)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_last  (slot_last),
        .slot_req   (slot_req),
        .dec        (dec)
    );

    tlcd_render u_render (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .adv   (adv),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
